[hdl/gdad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and the month length function for the Gregorian
// date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 16;
    localparam int AddW   = 16;
    localparam int RemW   = 17;   // day count never wraps at this width

    localparam int ModBase       = 25;  // year mod 25 gives the century test
    localparam int ModRecipW     = 17;
    localparam int ModRecipShift = 21;  // (y * ModRecip) >> 21 is y / 25 for any 16-bit y
    localparam int ModProdW      = YearW + ModRecipW;
    localparam int QuoW          = 12;  // 65535 / 25 fits in 12 bits
    localparam int ModMax        = ModBase - 1;
    localparam int MonDec        = 12;

    localparam logic [ModRecipW-1:0] ModRecip = 17'd83887;  // ceil(2^21 / 25)

    localparam logic [DayW-1:0] FebLeap   = 5'd29;
    localparam logic [DayW-1:0] FebCommon = 5'd28;

    typedef struct packed {
        logic [DayW-1:0]  in_day;
        logic [MonW-1:0]  in_month;
        logic [YearW-1:0] in_year;
        logic [AddW-1:0]  days_to_add;
    } gdad_in_t;

    typedef struct packed {
        logic [DayW-1:0]  out_day;
        logic [MonW-1:0]  out_month;
        logic [YearW-1:0] out_year;
        logic             year_overflow;
    } gdad_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new transaction
        logic mod_step;   // one step of year mod 25: quotient, then residue
        logic sum_step;   // add the length of one month before the start month
        logic walk_init;  // restart the month walk at January
        logic walk_step;  // subtract one month length and advance
        logic out_load;   // move the finished date into the output register
    } gdad_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_last;
        logic sum_done;
        logic walk_done;
        logic out_free;
    } gdad_sts_t;

    function automatic logic [DayW-1:0] days_in(input logic [MonW-1:0] m,
                                                input logic            leap);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? FebLeap : FebCommon;
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[hdl/gregorian_date_add_days.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date (4/100/400 leap rule) and returns the
// resulting date, with a flag when the year wraps past 65535.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | moves
//  --------+------------------------------+-----------+-------------------------
//  in      | in_valid, in_ready, in_data  | into      | start date + day count
//  out     | out_valid, out_ready, out_data| out of   | resulting date + flag
//
//  Sequence: load, mod (quotient, then residue), the sum of the months before
//  the start month, the month walk, then the output load; the month walker,
//  subtracting one month length per cycle, dominates for long day counts.
//  Reset: rst_n clears the sequencer and output valid only; no clearing pass.
//  Stalls: the result sits in an output register, so a new transaction is
//  accepted while it waits; a finished date holds in the walker until the
//  output register is free.
//
module gregorian_date_add_days (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  gdad_pkg::gdad_in_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output gdad_pkg::gdad_out_t out_data
);
    import gdad_pkg::*;

    gdad_cmd_t cmd;
    gdad_sts_t sts;

    // Sequencer: IDLE -> MOD (quotient, then residue of year mod 25) -> SUM
    // (months before the start month) -> WALK (month by month from January)
    // -> LOAD.
    gdad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: 17-bit day count, month counter, year with its residue mod 25
    // (kept in step with the year so the century test needs no divider).
    gdad_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A transaction in flight blocks the input for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    // The walker always lands on a real month.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_month >= 4'd1) && (out_data.out_month <= 4'd12))
        else $error("result month out of range");

    // A result is only produced through the sequencer's load step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid rose without a load");

endmodule
`default_nettype wire

[hdl/gdad_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: reduce year mod 25, sum the leading months, walk the months, load the result.
// ----------------------------------------------------------------------------
module gdad_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  gdad_pkg::gdad_sts_t sts,
    output gdad_pkg::gdad_cmd_t cmd
);
    import gdad_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_WALK = 5'b01000,
        ST_LOAD = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sts.sum_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/gdad_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_datapath
// Day count, month walker, year with its mod-25 residue, output register.
// ----------------------------------------------------------------------------
module gdad_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gdad_pkg::gdad_cmd_t cmd,
    output gdad_pkg::gdad_sts_t sts,
    input  gdad_pkg::gdad_in_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output gdad_pkg::gdad_out_t out_data
);
    import gdad_pkg::*;

    logic [RemW-1:0]  rem_reg,    rem_next;
    logic [MonW-1:0]  mon_reg,    mon_next;
    logic [MonW-1:0]  start_reg,  start_next;
    logic [YearW-1:0] year_reg,   year_next;
    logic [YearW-1:0] ymod_reg,   ymod_next;
    logic             kcnt_reg,   kcnt_next;
    logic [QuoW-1:0]  quo_reg,    quo_next;
    logic             ovf_reg,    ovf_next;
    logic             ovalid_reg, ovalid_next;
    gdad_out_t        odata_reg,  odata_next;

    logic [QuoW-1:0]  mod_quo;
    logic [YearW-1:0] mod_sub;
    logic             leap;
    logic [DayW-1:0]  len;

    // with y mod 4 == 0: leap unless y mod 100 == 0, except y mod 400 == 0
    assign leap    = (year_reg[1:0] == 2'b00) &&
                     ((ymod_reg[4:0] != 5'd0) || (year_reg[3:0] == 4'd0));
    assign len     = days_in(mon_reg, leap);
    // year / 25 by reciprocal multiply, then the residue in the following cycle from the registered quotient
    assign mod_quo = QuoW'((ModProdW'(ymod_reg) * ModProdW'(ModRecip)) >> ModRecipShift);
    assign mod_sub = YearW'(quo_reg) * YearW'(ModBase);

    assign sts.mod_last  = !kcnt_reg;
    assign sts.sum_done  = (mon_reg >= start_reg);
    assign sts.walk_done = (rem_reg <= RemW'(len));
    assign sts.out_free  = !ovalid_reg || out_ready;

    always_comb
    begin
        rem_next    = rem_reg;
        mon_next    = mon_reg;
        start_next  = start_reg;
        year_next   = year_reg;
        ymod_next   = ymod_reg;
        kcnt_next   = kcnt_reg;
        quo_next    = quo_reg;
        ovf_next    = ovf_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !out_ready;

        if (cmd.load)
        begin
            rem_next   = RemW'(in_data.in_day) + RemW'(in_data.days_to_add);
            mon_next   = MonW'(1);
            start_next = in_data.in_month;
            year_next  = in_data.in_year;
            ymod_next  = in_data.in_year;
            kcnt_next  = 1'b1;
            ovf_next   = 1'b0;
        end

        if (cmd.mod_step)
        begin
            if (kcnt_reg)
            begin
                quo_next = mod_quo;
            end
            else
            begin
                ymod_next = ymod_reg - mod_sub;
            end
            kcnt_next = 1'b0;
        end

        if (cmd.sum_step)
        begin
            rem_next = rem_reg + RemW'(len);
            mon_next = mon_reg + MonW'(1);
        end

        if (cmd.walk_init)
        begin
            mon_next = MonW'(1);
        end

        if (cmd.walk_step)
        begin
            rem_next = rem_reg - RemW'(len);
            if (mon_reg == MonW'(MonDec))
            begin
                mon_next = MonW'(1);
                if (year_reg == '1)
                begin
                    year_next = '0;
                    ymod_next = '0;
                    ovf_next  = 1'b1;
                end
                else
                begin
                    year_next = year_reg + YearW'(1);
                    ymod_next = (ymod_reg == YearW'(ModMax)) ? '0 : ymod_reg + YearW'(1);
                end
            end
            else
            begin
                mon_next = mon_reg + MonW'(1);
            end
        end

        if (cmd.out_load)
        begin
            odata_next.out_day       = rem_reg[DayW-1:0];
            odata_next.out_month     = mon_reg;
            odata_next.out_year      = year_reg;
            odata_next.year_overflow = ovf_reg;
            ovalid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        mon_reg   <= mon_next;
        start_reg <= start_next;
        year_reg  <= year_next;
        ymod_reg  <= ymod_next;
        kcnt_reg  <= kcnt_next;
        quo_reg   <= quo_next;
        ovf_reg   <= ovf_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule
`default_nettype wire
